/* src/spct_pkg.sv */
// Types and widths shared by the disc collision-time datapath.
package spct_pkg;

  localparam int A_W    = 66;   // |u|^2
  localparam int B_W    = 67;   // d.u, signed
  localparam int C_W    = 68;   // |d|^2 - (r1+r2)^2, signed
  localparam int MUL_W  = 68;   // operand width of the wide multipliers
  localparam int DET_W  = 132;  // nonnegative discriminant
  localparam int SQ_W   = DET_W / 2;
  localparam int MAG_W  = 68;   // |-b - sqrt(det)|
  localparam int NUM_W  = MAG_W + 32;
  localparam int T_W    = 64;

  localparam logic [31:0] MIN_TIME_RESET = 32'd1;
  localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic        [30:0] first_radius;
    logic        [30:0] second_radius;
  } in_item_t;

  typedef struct packed {
    logic                  root_exists;
    logic signed [T_W-1:0] time_to_hit;
    logic                  will_collide;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                  root_ok;
    logic [DET_W-1:0]      det;
    logic [A_W-1:0]        a;
    logic signed [B_W-1:0] b;
  } work_t;

  typedef struct packed {
    logic                  root_ok;
    logic [A_W-1:0]        a;
    logic signed [B_W-1:0] b;
  } side_t;

endpackage

/* src/spct_mul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
module spct_mul #(
  parameter int W = 68
) (
  input  logic           clk,
  input  logic [W-1:0]   op_a,
  input  logic [W-1:0]   op_b,
  output logic [2*W-1:0] prod
);

  localparam int H = W / 2;

  logic [2*H-1:0] pp_hh_r, pp_hl_r, pp_lh_r, pp_ll_r;
  logic [2*W-1:0] prod_r;

  always_ff @(posedge clk) begin
    pp_hh_r <= op_a[W-1:H] * op_b[W-1:H];
    pp_hl_r <= op_a[W-1:H] * op_b[H-1:0];
    pp_lh_r <= op_a[H-1:0] * op_b[W-1:H];
    pp_ll_r <= op_a[H-1:0] * op_b[H-1:0];
    prod_r  <= ((2*W)'(pp_hh_r) << (2*H))
             + (((2*W)'(pp_hl_r) + (2*W)'(pp_lh_r)) << H)
             + (2*W)'(pp_ll_r);
  end

  assign prod = prod_r;

endmodule

/* src/spct_front.sv */
// Front: relative motion, quadratic coefficients, discriminant and root check.
module spct_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  spct_pkg::in_item_t  item,
  output logic                wk_valid,
  output spct_pkg::work_t     wk
);

  logic [5:0] v_r;

  logic signed [32:0] dx_r, dy_r, ux_r, uy_r;
  logic [31:0]        rs_r;
  logic signed [65:0] uxux_r, uyuy_r, dxux_r, dyuy_r, dxdx_r, dydy_r;
  logic [63:0]        rsrs_r;
  logic [spct_pkg::A_W-1:0]        a_r, a_d1_r, a_d2_r;
  logic signed [spct_pkg::B_W-1:0] b_r, b_d1_r, b_d2_r;
  logic signed [spct_pkg::C_W-1:0] c_r;
  logic                            cneg_d1_r, cneg_d2_r;
  logic [spct_pkg::MUL_W-1:0]      bmag, cmag;
  logic [2*spct_pkg::MUL_W-1:0]    bb, ac;
  logic signed [2*spct_pkg::MUL_W-1:0] det;
  spct_pkg::work_t wk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], take};
    end
  end

  always_comb begin
    bmag = b_r[spct_pkg::B_W-1] ? spct_pkg::MUL_W'(-b_r) : spct_pkg::MUL_W'(b_r);
    cmag = c_r[spct_pkg::C_W-1] ? spct_pkg::MUL_W'(-c_r) : spct_pkg::MUL_W'(c_r);
    det  = cneg_d2_r ? $signed(bb + ac) : $signed(bb - ac);
  end

  spct_mul #(.W(spct_pkg::MUL_W)) u_bb (
    .clk(clk), .op_a(bmag), .op_b(bmag), .prod(bb)
  );

  spct_mul #(.W(spct_pkg::MUL_W)) u_ac (
    .clk(clk), .op_a(spct_pkg::MUL_W'(a_r)), .op_b(cmag), .prod(ac)
  );

  always_ff @(posedge clk) begin
    dx_r <= $signed({item.first_pos_x[31], item.first_pos_x})
          - $signed({item.second_pos_x[31], item.second_pos_x});
    dy_r <= $signed({item.first_pos_y[31], item.first_pos_y})
          - $signed({item.second_pos_y[31], item.second_pos_y});
    ux_r <= $signed({item.first_vel_x[31], item.first_vel_x})
          - $signed({item.second_vel_x[31], item.second_vel_x});
    uy_r <= $signed({item.first_vel_y[31], item.first_vel_y})
          - $signed({item.second_vel_y[31], item.second_vel_y});
    rs_r <= {1'b0, item.first_radius} + {1'b0, item.second_radius};

    uxux_r <= ux_r * ux_r;
    uyuy_r <= uy_r * uy_r;
    dxux_r <= dx_r * ux_r;
    dyuy_r <= dy_r * uy_r;
    dxdx_r <= dx_r * dx_r;
    dydy_r <= dy_r * dy_r;
    rsrs_r <= rs_r * rs_r;

    a_r <= $unsigned(uxux_r) + $unsigned(uyuy_r);
    b_r <= spct_pkg::B_W'(dxux_r) + spct_pkg::B_W'(dyuy_r);
    c_r <= spct_pkg::C_W'(dxdx_r) + spct_pkg::C_W'(dydy_r) - $signed({4'b0, rsrs_r});

    // hold a, b and the sign of c alongside the multipliers
    a_d1_r    <= a_r;
    b_d1_r    <= b_r;
    cneg_d1_r <= c_r[spct_pkg::C_W-1];
    a_d2_r    <= a_d1_r;
    b_d2_r    <= b_d1_r;
    cneg_d2_r <= cneg_d1_r;

    wk_r.root_ok <= !det[2*spct_pkg::MUL_W-1] && (a_d2_r != '0);
    wk_r.det     <= det[spct_pkg::DET_W-1:0];
    wk_r.a       <= a_d2_r;
    wk_r.b       <= b_d2_r;
  end

  assign wk_valid = v_r[5];
  assign wk       = wk_r;

endmodule

/* src/spct_queue.sv */
// Two-entry queue between the classifying front and the solving back.
module spct_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  spct_pkg::work_t push_item,
  output logic            full,
  output logic            pop_valid,
  output spct_pkg::work_t pop_item
);

  spct_pkg::work_t mem [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       pop;

  // the back never stalls: drain whenever something is held
  assign pop       = cnt_r != 2'd0;
  assign pop_valid = pop;
  assign pop_item  = mem[rd_r];
  assign full      = cnt_r == 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && !push) |=> cnt_r == 2'd0)
    else $error("queue filled without a push");

endmodule

/* src/spct_back.sv */
// Back: pipelined square root, pipelined division, rounding and saturation.
module spct_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wk_valid,
  input  spct_pkg::work_t      wk,
  input  logic [31:0]          min_time,
  output logic                 out_valid,
  output spct_pkg::out_item_t  out_item
);

  localparam int SQ_W  = spct_pkg::SQ_W;
  localparam int DET_W = spct_pkg::DET_W;
  localparam int A_W   = spct_pkg::A_W;
  localparam int NUM_W = spct_pkg::NUM_W;
  localparam int MAG_W = spct_pkg::MAG_W;
  localparam int T_W   = spct_pkg::T_W;

  // square-root stages
  logic                 sv_r    [0:SQ_W];
  spct_pkg::side_t      sside_r [0:SQ_W];
  logic [DET_W-1:0]     src_r   [0:SQ_W];
  logic [SQ_W+1:0]      srem_r  [0:SQ_W];
  logic [SQ_W-1:0]      sroot_r [0:SQ_W];
  logic [DET_W-1:0]     src_nxt   [1:SQ_W];
  logic [SQ_W+1:0]      srem_nxt  [1:SQ_W];
  logic [SQ_W-1:0]      sroot_nxt [1:SQ_W];

  // division stages
  logic                 dv_r    [0:NUM_W];
  logic                 dok_r   [0:NUM_W];
  logic                 dneg_r  [0:NUM_W];
  logic [A_W-1:0]       da_r    [0:NUM_W];
  logic [NUM_W-1:0]     dnum_r  [0:NUM_W];
  logic [NUM_W-1:0]     dquo_r  [0:NUM_W];
  logic [A_W-1:0]       drem_r  [0:NUM_W];
  logic [NUM_W-1:0]     dquo_nxt [1:NUM_W];
  logic [A_W-1:0]       drem_nxt [1:NUM_W];

  logic signed [MAG_W:0] num;
  logic                  neg;
  logic [MAG_W-1:0]      mag;
  logic [NUM_W:0]        mround;
  logic [T_W-1:0]        t;
  logic                  out_valid_r;
  spct_pkg::out_item_t   out_item_r, out_nxt;

  always_comb begin
    logic [SQ_W+3:0] rem2, trial;
    rem2  = '0;
    trial = '0;
    for (int k = 0; k < SQ_W; k++) begin
      rem2  = {srem_r[k], src_r[k][DET_W-1 -: 2]};
      trial = (SQ_W+4)'({sroot_r[k], 2'b01});
      src_nxt[k+1] = src_r[k] << 2;
      if (rem2 >= trial) begin
        srem_nxt[k+1]  = (SQ_W+2)'(rem2 - trial);
        sroot_nxt[k+1] = {sroot_r[k][SQ_W-2:0], 1'b1};
      end else begin
        srem_nxt[k+1]  = (SQ_W+2)'(rem2);
        sroot_nxt[k+1] = {sroot_r[k][SQ_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [A_W:0] rem2;
    rem2 = '0;
    for (int k = 0; k < NUM_W; k++) begin
      rem2 = {drem_r[k], dnum_r[k][NUM_W-1]};
      if (rem2 >= {1'b0, da_r[k]}) begin
        drem_nxt[k+1] = A_W'(rem2 - {1'b0, da_r[k]});
        dquo_nxt[k+1] = {dquo_r[k][NUM_W-2:0], 1'b1};
      end else begin
        drem_nxt[k+1] = A_W'(rem2);
        dquo_nxt[k+1] = {dquo_r[k][NUM_W-2:0], 1'b0};
      end
    end
  end

  // numerator of the earlier root: -b - floor(sqrt(det))
  always_comb begin
    num = -((MAG_W+1)'(sside_r[SQ_W].b)) - $signed({3'b0, sroot_r[SQ_W]});
    neg = num[MAG_W];
    mag = neg ? MAG_W'(-num) : MAG_W'(num);
  end

  // round toward minus infinity, then saturate to 64 bits
  always_comb begin
    mround = {1'b0, dquo_r[NUM_W]} + (NUM_W+1)'(drem_r[NUM_W] != '0);
    if (!dneg_r[NUM_W]) begin
      t = (dquo_r[NUM_W][NUM_W-1:T_W-1] != '0) ? spct_pkg::T_MAX
                                                : dquo_r[NUM_W][T_W-1:0];
    end else begin
      t = (mround[NUM_W:T_W-1] != '0) ? spct_pkg::T_MIN : T_W'(-mround[T_W-1:0]);
    end
    if (dok_r[NUM_W]) begin
      out_nxt.root_exists  = 1'b1;
      out_nxt.time_to_hit  = t;
      out_nxt.will_collide = !t[T_W-1] && (t > T_W'(min_time));
    end else begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ_W; k++) sv_r[k] <= 1'b0;
      for (int k = 0; k <= NUM_W; k++) dv_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sv_r[0] <= wk_valid;
      for (int k = 0; k < SQ_W; k++) sv_r[k+1] <= sv_r[k];
      dv_r[0] <= sv_r[SQ_W];
      for (int k = 0; k < NUM_W; k++) dv_r[k+1] <= dv_r[k];
      out_valid_r <= dv_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    sside_r[0] <= '{root_ok: wk.root_ok, a: wk.a, b: wk.b};
    src_r[0]   <= wk.det;
    srem_r[0]  <= '0;
    sroot_r[0] <= '0;
    for (int k = 1; k <= SQ_W; k++) begin
      sside_r[k] <= sside_r[k-1];
      src_r[k]   <= src_nxt[k];
      srem_r[k]  <= srem_nxt[k];
      sroot_r[k] <= sroot_nxt[k];
    end

    dok_r[0]  <= sside_r[SQ_W].root_ok;
    dneg_r[0] <= neg;
    da_r[0]   <= sside_r[SQ_W].a;
    dnum_r[0] <= {mag, 32'b0};
    dquo_r[0] <= '0;
    drem_r[0] <= '0;
    for (int k = 1; k <= NUM_W; k++) begin
      dok_r[k]  <= dok_r[k-1];
      dneg_r[k] <= dneg_r[k-1];
      da_r[k]   <= da_r[k-1];
      dnum_r[k] <= dnum_r[k-1] << 1;
      dquo_r[k] <= dquo_nxt[k];
      drem_r[k] <= drem_nxt[k];
    end

    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[SQ_W] |=> dv_r[0])
    else $error("item lost between root and divide stages");
  assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[NUM_W] && !dok_r[NUM_W]) |=> (out_item.time_to_hit == '0))
    else $error("time not cleared without a root");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.will_collide) |-> out_item.root_exists)
    else $error("collide flag without a root");

endmodule

/* src/sphere_pair_collision_time.sv */
// Collision time of two discs: start to out_valid passes 6 front stages,
// the queue, the queue read register, 66 root stages, 1 numerator stage, 100 divide
// stages and 1 output register. One item per cycle: busy stays low since the back
// drains the queue every cycle. Results appear for one cycle only.
// rst_n is synchronous, active low; it clears all valid flags and sets min_time to 1.
module sphere_pair_collision_time (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  spct_pkg::in_item_t   in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  output spct_pkg::out_item_t  out_item
);

  logic            take;
  logic            wk_valid, q_valid, q_full;
  spct_pkg::work_t wk, q_item;
  logic [31:0]     min_time_r;

  assign take      = start && !busy;
  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_time_r <= spct_pkg::MIN_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_time_r <= cfg_data;
    end
  end

  spct_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .item(in_item),
    .wk_valid(wk_valid), .wk(wk)
  );

  spct_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(wk_valid), .push_item(wk),
    .full(q_full), .pop_valid(q_valid), .pop_item(q_item)
  );

  spct_back u_back (
    .clk(clk), .rst_n(rst_n), .wk_valid(q_valid), .wk(q_item),
    .min_time(min_time_r), .out_valid(out_valid), .out_item(out_item)
  );

  assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised with a free-running back");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> (min_time_r == $past(cfg_data)))
    else $error("threshold write lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.will_collide) |-> !out_item.time_to_hit[63])
    else $error("collide flag on a negative time");

endmodule
